/* hdl/bba_pkg.sv */
// Shared types, constants and the size-to-level function of the buddy block allocator.
// Used by buddy_block_allocator; depends on nothing else.
`default_nettype none
package bba_pkg;

  localparam int MAX_LEVEL_DEF = 10;
  localparam int LVL_W         = 5;
  localparam int SIZE_W        = 11;
  localparam int OFF_W         = 10;
  localparam int CFG_W         = 4;
  localparam int WORD_LG_MAX   = 5;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_TOO_BIG  = 2'd2
  } status_t;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_t;

  typedef enum logic [3:0] {
    S_SWEEP,
    S_IDLE,
    S_A_RD,
    S_A_CHK,
    S_A_TAKE,
    S_S_RD,
    S_S_WR,
    S_F_RD,
    S_F_CHK,
    S_T_RD,
    S_T_WR,
    S_DONE
  } state_t;

  function automatic logic [LVL_W-1:0] level_of(input logic [SIZE_W-1:0] size);
    logic [LVL_W-1:0] r;
    r = LVL_W'(SIZE_W);
    for (int s = SIZE_W; s >= 0; s--) begin
      if ((13'(1) << s) >= 13'(size)) begin
        r = LVL_W'(s);
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* hdl/bba_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// Has no dependencies.
`default_nettype none
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

/* hdl/buddy_block_allocator.sv */
// Buddy block allocator: top level with control sequencer and the free bitmap memory.
// Depends on bba_pkg and bba_ram.
//
//   Channel  Direction  Transfer content
//   in_      slave      tuser: action; tdata: request_size, block_offset
//   out_     master     tuser: status; tdata: result_offset
//   cfg_     write      top_level
//
// Every memory access is a read and then a check or write. An allocate scans bitmap words
// from its level upward and then splits the found block down to the requested level; a free
// examines buddies upward and merges them; an oversized request goes straight to the output.
// After reset or a write of top_level the bitmap is rewritten by a sweep of one word per
// cycle over all 64 words, leaving only the top-level block free, while no input is accepted.
// One result waiting on the output does not stop the next input transfer; the item after
// it finishes and then waits until the output register empties.
`default_nettype none
module buddy_block_allocator (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [23:0]                 in_tdata,  // request_size, block_offset
  input  wire logic                        in_tuser,  // action
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic      [15:0]                 out_tdata, // result_offset
  output logic      [1:0]                  out_tuser, // status
  input  wire logic                        cfg_we,
  input  wire logic [bba_pkg::CFG_W-1:0]   cfg_wdata
);
  import bba_pkg::*;

  localparam int MAX_LEVEL = MAX_LEVEL_DEF;
  localparam int WL  = (MAX_LEVEL + 1 < WORD_LG_MAX) ? MAX_LEVEL + 1 : WORD_LG_MAX;
  localparam int W   = 1 << WL;
  localparam int AW  = (MAX_LEVEL + 1 - WL < 1) ? 1 : MAX_LEVEL + 1 - WL;
  localparam int NXW = AW + WL;
  localparam int OW  = MAX_LEVEL;

  state_t              state_r, state_nxt;
  logic [CFG_W-1:0]    cfg_r;
  logic [AW-1:0]       addr_r, addr_nxt;
  logic [WL-1:0]       bit_r, bit_nxt;
  logic [LVL_W-1:0]    lvl_r, lvl_nxt, cur_r, cur_nxt;
  logic [OW-1:0]       off_r, off_nxt;
  status_t             st_r, st_nxt;
  logic [OW-1:0]       res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  status_t             out_st_r, out_st_nxt;
  logic [OW-1:0]       out_res_r, out_res_nxt;

  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [W-1:0]        wr_data, rd_data;

  logic [LVL_W-1:0]    top;
  logic [LVL_W-1:0]    in_lvl;
  logic [OW-1:0]       in_off;
  logic [NXW-1:0]      lo, hi, n0, nd, hit_node;
  logic [W-1:0]        hit_vec, bit_oh;
  logic [WL-1:0]       hit_pos;
  logic [OW-1:0]       t_off, m_off;
  logic [LVL_W-1:0]    cm1, cp1;

  function automatic logic [NXW-1:0] base_f(input logic [LVL_W-1:0] l);
    return NXW'(1) << (MAX_LEVEL - int'(l));
  endfunction

  function automatic logic [NXW-1:0] node_f(input logic [LVL_W-1:0] l, input logic [OW-1:0] o);
    return base_f(l) + NXW'(o >> l);
  endfunction

  bba_ram #(.WIDTH(W), .DEPTH(1 << AW)) u_map (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (addr_r),
    .rd_data (rd_data)
  );

  assign top    = (LVL_W'(cfg_r) > LVL_W'(MAX_LEVEL)) ? LVL_W'(MAX_LEVEL) : LVL_W'(cfg_r);
  assign in_lvl = level_of(in_tdata[SIZE_W-1:0]);
  assign in_off = OW'(in_tdata[SIZE_W +: OFF_W]) & ((OW'(1) << top) - OW'(1))
                  & ~((OW'(1) << in_lvl) - OW'(1));
  assign lo     = base_f(cur_r);
  assign hi     = lo + (NXW'(1) << (top - cur_r)) - NXW'(1);
  assign n0     = base_f(top);
  assign bit_oh = W'(1) << bit_r;
  assign cm1    = cur_r - LVL_W'(1);
  assign cp1    = cur_r + LVL_W'(1);
  assign hit_node = {addr_r, bit_r};
  assign t_off  = OW'((hit_node - lo) << cur_r);
  assign m_off  = off_r & ~(OW'(1) << cur_r);

  always_comb begin
    hit_pos = '0;
    for (int b = W - 1; b >= 0; b--) begin
      hit_vec[b] = rd_data[b] && ({addr_r, WL'(b)} >= lo) && ({addr_r, WL'(b)} <= hi);
      if (hit_vec[b]) begin
        hit_pos = WL'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      cfg_r       <= CFG_W'(MAX_LEVEL_DEF);
      addr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= cfg_we ? S_SWEEP : state_nxt;
      addr_r      <= cfg_we ? '0 : addr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
    end
    bit_r     <= bit_nxt;
    lvl_r     <= lvl_nxt;
    cur_r     <= cur_nxt;
    off_r     <= off_nxt;
    st_r      <= st_nxt;
    res_r     <= res_nxt;
    out_st_r  <= out_st_nxt;
    out_res_r <= out_res_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    bit_nxt       = bit_r;
    lvl_nxt       = lvl_r;
    cur_nxt       = cur_r;
    off_nxt       = off_r;
    st_nxt        = st_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_st_nxt    = out_st_r;
    out_res_nxt   = out_res_r;
    wr_en         = 1'b0;
    wr_addr       = addr_r;
    wr_data       = rd_data;
    in_tready     = 1'b0;
    nd            = '0;
    unique case (state_r)
      S_SWEEP: begin
        wr_en   = 1'b1;
        wr_data = (addr_r == n0[NXW-1:WL]) ? (W'(1) << n0[WL-1:0]) : '0;
        addr_nxt = addr_r + AW'(1);
        if (addr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          lvl_nxt = in_lvl;
          cur_nxt = in_lvl;
          st_nxt  = ST_OK;
          res_nxt = '0;
          if (in_lvl > top) begin
            st_nxt    = ST_TOO_BIG;
            state_nxt = S_DONE;
          end else if (action_t'(in_tuser) == ACT_ALLOC) begin
            nd        = base_f(in_lvl);
            addr_nxt  = nd[NXW-1:WL];
            state_nxt = S_A_RD;
          end else begin
            off_nxt = in_off;
            if (in_lvl < top) begin
              nd        = node_f(in_lvl, in_off ^ (OW'(1) << in_lvl));
              state_nxt = S_F_RD;
            end else begin
              nd        = node_f(in_lvl, in_off);
              state_nxt = S_T_RD;
            end
            addr_nxt = nd[NXW-1:WL];
            bit_nxt  = nd[WL-1:0];
          end
        end
      end
      S_A_RD: state_nxt = S_A_CHK;
      S_A_CHK: begin
        if (|hit_vec) begin
          bit_nxt   = hit_pos;
          state_nxt = S_A_TAKE;
        end else if (addr_r == hi[NXW-1:WL]) begin
          if (cur_r == top) begin
            st_nxt    = ST_NO_SPACE;
            state_nxt = S_DONE;
          end else begin
            cur_nxt   = cp1;
            nd        = base_f(cp1);
            addr_nxt  = nd[NXW-1:WL];
            state_nxt = S_A_RD;
          end
        end else begin
          addr_nxt  = addr_r + AW'(1);
          state_nxt = S_A_RD;
        end
      end
      S_A_TAKE: begin
        wr_en   = 1'b1;
        wr_data = rd_data & ~bit_oh;
        off_nxt = t_off;
        res_nxt = t_off;
        if (cur_r == lvl_r) begin
          state_nxt = S_DONE;
        end else begin
          cur_nxt   = cm1;
          nd        = node_f(cm1, t_off + (OW'(1) << cm1));
          addr_nxt  = nd[NXW-1:WL];
          bit_nxt   = nd[WL-1:0];
          state_nxt = S_S_RD;
        end
      end
      S_S_RD: state_nxt = S_S_WR;
      S_S_WR: begin
        wr_en   = 1'b1;
        wr_data = rd_data | bit_oh;
        if (cur_r == lvl_r) begin
          state_nxt = S_DONE;
        end else begin
          cur_nxt   = cm1;
          nd        = node_f(cm1, off_r + (OW'(1) << cm1));
          addr_nxt  = nd[NXW-1:WL];
          bit_nxt   = nd[WL-1:0];
          state_nxt = S_S_RD;
        end
      end
      S_F_RD: state_nxt = S_F_CHK;
      S_F_CHK: begin
        if ((rd_data & bit_oh) == '0) begin
          nd        = node_f(cur_r, off_r);
          state_nxt = S_T_RD;
        end else begin
          wr_en   = 1'b1;
          wr_data = rd_data & ~bit_oh;
          off_nxt = m_off;
          cur_nxt = cp1;
          if (cp1 < top) begin
            nd        = node_f(cp1, m_off ^ (OW'(1) << cp1));
            state_nxt = S_F_RD;
          end else begin
            nd        = node_f(cp1, m_off);
            state_nxt = S_T_RD;
          end
        end
        addr_nxt = nd[NXW-1:WL];
        bit_nxt  = nd[WL-1:0];
      end
      S_T_RD: state_nxt = S_T_WR;
      S_T_WR: begin
        wr_en     = 1'b1;
        wr_data   = rd_data | bit_oh;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = st_r;
          out_res_nxt   = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_SWEEP;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_st_r;
  assign out_tdata  = 16'(OFF_W'(out_res_r));

endmodule
`default_nettype wire
